[rtl/knn_pkg.sv]
package knn_pkg;

    localparam int MaxSamples  = 256;
    localparam int MaxDims     = 16;
    localparam int MaxK        = 16;
    localparam int MaxClasses  = 15;
    localparam int FeatureBits = 16;

    localparam int SampleBits = $clog2(MaxSamples);
    localparam int DimBits    = $clog2(MaxDims);
    localparam int KBits      = $clog2(MaxK);
    localparam int StoreBits  = SampleBits + DimBits;
    localparam int DistBits   = 40;
    localparam int SumBits    = 45;
    localparam int ThrBits    = 24;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_TRAIN  = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_THRESH = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ERR_OK       = 3'd0,
        ERR_EMPTY    = 3'd1,
        ERR_K_LARGE  = 3'd2,
        ERR_ZERO_LAB = 3'd3,
        ERR_LENGTH   = 3'd4
    } t_err;

    localparam logic [2:0] CfgK      = 3'd0;
    localparam logic [2:0] CfgMethod = 3'd1;
    localparam logic [2:0] CfgReject = 3'd2;
    localparam logic [2:0] CfgLength = 3'd3;
    localparam logic [2:0] CfgClass  = 3'd4;

    typedef struct packed {
        logic [1:0]             func;
        logic [FeatureBits-1:0] feature_value;
        logic [3:0]             class_label;
        logic                   last_feature;
        logic [ThrBits-1:0]     threshold_value;
    } t_in;

    typedef struct packed {
        logic [3:0] predicted_label;
        logic [4:0] vote_count;
        logic [2:0] error_code;
    } t_out;

    // Job handed from the front to the back: either a finished result or a query scan.
    typedef struct packed {
        logic    scan;
        t_out    res;
        logic [SampleBits:0] count;
    } t_job;

endpackage

[rtl/knn_if.sv]
interface knn_in_if;
    logic          valid;
    logic          ready;
    knn_pkg::t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface knn_out_if;
    logic          valid;
    logic          ready;
    knn_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/knn_front.sv]
module knn_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  knn_pkg::t_in                  i_item,
    input  logic [4:0]                    i_vector_length,
    input  logic [4:0]                    i_neighbour_count,
    output logic                          o_job_valid,
    input  logic                          i_job_ready,
    output knn_pkg::t_job                 o_job,
    input  logic                          i_busy,
    output logic                          o_st_we,
    output logic [knn_pkg::StoreBits-1:0] o_st_addr,
    output logic [knn_pkg::FeatureBits-1:0] o_st_data,
    output logic                          o_lab_we,
    output logic [knn_pkg::SampleBits-1:0] o_lab_addr,
    output logic [3:0]                    o_lab_data,
    output logic                          o_q_we,
    output logic [knn_pkg::DimBits-1:0]   o_q_addr,
    output logic                          o_th_we,
    output logic [3:0]                    o_th_idx
);
    import knn_pkg::*;

    logic [SampleBits:0] r_count;
    logic [DimBits:0]    r_elem;
    logic                r_ovf;
    logic                keep, good, is_vec, emits;
    logic [4:0]          kk;
    logic [SampleBits:0] n_count;
    t_job                job;

    // Query features must not overwrite the buffer while a scan reads it.
    assign o_ready = i_job_ready && !(i_busy && i_item.func == FUNC_QUERY);
    wire acc = i_valid && o_ready;

    assign is_vec = i_item.func == FUNC_TRAIN || i_item.func == FUNC_QUERY;
    assign keep = {1'b0, r_elem} < 6'(MaxDims) && {1'b0, r_elem} < {1'b0, i_vector_length}
                  && (i_item.func == FUNC_QUERY || r_count < (SampleBits+1)'(MaxSamples));
    wire [DimBits:0] elem_after = keep ? r_elem + 1'b1 : r_elem;
    assign good = !(r_ovf || !keep) && {1'b0, elem_after} == {1'b0, i_vector_length};
    assign emits = is_vec && i_item.last_feature;

    assign kk = (i_neighbour_count == 5'd0) ? 5'd1 :
                (i_neighbour_count > 5'(MaxK)) ? 5'(MaxK) : i_neighbour_count;

    always_comb begin
        job = '0;
        job.count = r_count;
        if (i_item.func == FUNC_TRAIN) begin
            job.res.error_code = (good && r_count < (SampleBits+1)'(MaxSamples)) ? ERR_OK
                                                                                 : ERR_LENGTH;
        end else if (r_count == '0) begin
            job.res.error_code = ERR_EMPTY;
        end else if (!good) begin
            job.res.error_code = ERR_LENGTH;
        end else if ({4'd0, kk} > r_count) begin
            job.res.error_code = ERR_K_LARGE;
        end else begin
            job.scan = 1'b1;
        end
    end

    assign o_job       = job;
    assign o_job_valid = acc && emits;

    assign o_st_we   = acc && i_item.func == FUNC_TRAIN && keep;
    assign o_st_addr = {r_count[SampleBits-1:0], r_elem[DimBits-1:0]};
    assign o_st_data = i_item.feature_value;
    assign o_q_we    = acc && i_item.func == FUNC_QUERY && keep;
    assign o_q_addr  = r_elem[DimBits-1:0];
    assign o_lab_we  = acc && emits && i_item.func == FUNC_TRAIN && good
                       && r_count < (SampleBits+1)'(MaxSamples);
    assign o_lab_addr = r_count[SampleBits-1:0];
    assign o_lab_data = i_item.class_label;
    assign o_th_we   = acc && i_item.func == FUNC_THRESH && i_item.class_label != 4'd0;
    assign o_th_idx  = i_item.class_label - 4'd1;

    assign n_count = o_lab_we ? r_count + 1'b1 : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_elem  <= '0;
            r_ovf   <= 1'b0;
        end else if (acc) begin
            if (i_item.func == FUNC_CLEAR) begin
                r_count <= '0;
                r_elem  <= '0;
                r_ovf   <= 1'b0;
            end else if (is_vec) begin
                if (i_item.last_feature) begin
                    r_elem <= '0;
                    r_ovf  <= 1'b0;
                end else begin
                    r_elem <= elem_after;
                    r_ovf  <= r_ovf || !keep;
                end
                r_count <= n_count;
            end
        end
    end
endmodule

[rtl/knn_back.sv]
module knn_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    output logic                          o_job_ready,
    input  knn_pkg::t_job                 i_job,
    output logic                          o_busy,
    input  logic [4:0]                    i_neighbour_count,
    input  logic                          i_distance_method,
    input  logic                          i_null_reject_enable,
    input  logic [4:0]                    i_vector_length,
    input  logic [3:0]                    i_num_classes,
    input  logic                          i_st_we,
    input  logic [knn_pkg::StoreBits-1:0] i_st_addr,
    input  logic [knn_pkg::FeatureBits-1:0] i_st_data,
    input  logic                          i_lab_we,
    input  logic [knn_pkg::SampleBits-1:0] i_lab_addr,
    input  logic [3:0]                    i_lab_data,
    input  logic                          i_q_we,
    input  logic [knn_pkg::DimBits-1:0]   i_q_addr,
    input  logic [knn_pkg::ThrBits-1:0]   i_th_data,
    input  logic                          i_th_we,
    input  logic [3:0]                    i_th_idx,
    output logic                          o_valid,
    input  logic                          i_ready,
    output knn_pkg::t_out                 o_data
);
    import knn_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DIST  = 9'b000000010,
        S_SQRT  = 9'b000000100,
        S_MAX   = 9'b000001000,
        S_INS   = 9'b000010000,
        S_VOTE  = 9'b000100000,
        S_BEST  = 9'b001000000,
        S_REJ   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    logic [FeatureBits-1:0] r_fmem [MaxSamples*MaxDims];
    logic [3:0]             r_lmem [MaxSamples];
    logic [FeatureBits-1:0] r_qbuf [MaxDims];
    logic [ThrBits-1:0]     r_thr  [MaxClasses];
    logic [MaxClasses-1:0]  r_thr_v;

    logic [DistBits-1:0]    r_nd [MaxK];
    logic [3:0]             r_nl [MaxK];
    logic [4:0]             r_votes [MaxClasses];
    logic [SumBits-1:0]     r_sums  [MaxClasses];

    t_state                 r_state;
    logic                   r_oq_v;
    t_out                   r_oq;
    logic [SampleBits:0]    r_cnt, r_smp;
    logic [DimBits:0]       r_j;
    logic                   r_rd_v;
    logic [DimBits-1:0]     r_rd_j;
    logic [FeatureBits-1:0] r_fd;
    logic [3:0]             r_lab;
    logic [DistBits-1:0]    r_acc;
    logic [DistBits-1:0]    r_x, r_r, r_bit;
    logic [4:0]             r_n, r_m, r_k;
    logic [KBits-1:0]       r_mi;
    logic [3:0]             r_c, r_best, r_nc;
    logic                   r_zero;
    logic [SumBits-1:0]     r_prod;

    wire [FeatureBits:0] diff = {r_qbuf[r_rd_j][FeatureBits-1], r_qbuf[r_rd_j]}
                                - {r_fd[FeatureBits-1], r_fd};
    wire [FeatureBits:0] adiff = diff[FeatureBits] ? -diff : diff;
    wire [33:0] sq = adiff * adiff;

    assign o_busy      = r_state != S_IDLE;
    assign o_job_ready = r_state == S_IDLE && !r_oq_v;
    assign o_valid     = r_oq_v;
    assign o_data      = r_oq;

    wire [StoreBits-1:0] rd_addr = {r_smp[SampleBits-1:0], r_j[DimBits-1:0]};
    wire [DistBits-1:0] rb = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (i_st_we) r_fmem[i_st_addr] <= i_st_data;
        if (i_lab_we) r_lmem[i_lab_addr] <= i_lab_data;
        if (i_q_we) r_qbuf[i_q_addr] <= i_st_data;
        if (i_th_we && i_th_idx < 4'(MaxClasses)) r_thr[i_th_idx] <= i_th_data;
        r_fd  <= r_fmem[rd_addr];
        r_lab <= r_lmem[r_smp[SampleBits-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_v <= '0;
        end else if (i_th_we && i_th_idx < 4'(MaxClasses)) begin
            r_thr_v[i_th_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oq_v  <= 1'b0;
            r_rd_v  <= 1'b0;
        end else begin
            if (r_oq_v && i_ready) r_oq_v <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid && o_job_ready) begin
                        if (i_job.scan) begin
                            r_state <= S_DIST;
                            r_cnt   <= i_job.count;
                            r_smp   <= '0;
                            r_j     <= '0;
                            r_rd_v  <= 1'b0;
                            r_acc   <= '0;
                            r_n     <= '0;
                            r_k     <= (i_neighbour_count == 5'd0) ? 5'd1 :
                                       (i_neighbour_count > 5'(MaxK)) ? 5'(MaxK)
                                                                      : i_neighbour_count;
                            r_nc    <= (i_num_classes == 4'd0) ? 4'd1 : i_num_classes;
                        end else begin
                            r_oq   <= i_job.res;
                            r_oq_v <= 1'b1;
                        end
                    end
                end
                S_DIST: begin
                    // One feature a cycle; the memory read is registered behind the address, and r_rd_v marks its data.
                    if (r_rd_v) begin
                        r_acc <= r_acc + (i_distance_method ? DistBits'(adiff)
                                                            : DistBits'(sq));
                    end
                    if ({1'b0, r_j} < {1'b0, i_vector_length} && r_j < (DimBits+1)'(MaxDims)) begin
                        r_rd_v <= 1'b1;
                        r_rd_j <= r_j[DimBits-1:0];
                        r_j    <= r_j + 1'b1;
                    end else if (r_rd_v) begin
                        r_rd_v <= 1'b0;
                    end else begin
                        r_x   <= r_acc;
                        r_r   <= '0;
                        r_bit <= DistBits'(1) << (DistBits - 2);
                        r_state <= i_distance_method ? S_MAX : S_SQRT;
                        r_m   <= 5'd1;
                        r_mi  <= '0;
                    end
                end
                S_SQRT: begin
                    if (r_bit == '0) begin
                        r_acc   <= r_r;
                        r_state <= S_MAX;
                    end else begin
                        if (r_x >= rb) begin
                            r_x <= r_x - rb;
                            r_r <= (r_r >> 1) + r_bit;
                        end else begin
                            r_r <= r_r >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_MAX: begin
                    if (r_n < r_k) begin
                        r_nd[r_n[KBits-1:0]] <= r_acc;
                        r_nl[r_n[KBits-1:0]] <= r_lab;
                        r_n     <= r_n + 5'd1;
                        r_state <= S_INS;
                    end else if (r_m < r_n) begin
                        if (r_nd[r_m[KBits-1:0]] > r_nd[r_mi]) r_mi <= r_m[KBits-1:0];
                        r_m <= r_m + 5'd1;
                    end else begin
                        if (r_acc < r_nd[r_mi]) begin
                            r_nd[r_mi] <= r_acc;
                            r_nl[r_mi] <= r_lab;
                        end
                        r_state <= S_INS;
                    end
                end
                S_INS: begin
                    if (r_smp + 1'b1 < r_cnt) begin
                        r_smp   <= r_smp + 1'b1;
                        r_j     <= '0;
                        r_acc   <= '0;
                        r_state <= S_DIST;
                    end else begin
                        for (int c = 0; c < MaxClasses; c++) begin
                            r_votes[c] <= '0;
                            r_sums[c]  <= '0;
                        end
                        r_m     <= '0;
                        r_zero  <= 1'b0;
                        r_state <= S_VOTE;
                    end
                end
                S_VOTE: begin
                    if (r_m < r_n) begin
                        if (r_nl[r_m[KBits-1:0]] == 4'd0) begin
                            r_zero <= 1'b1;
                        end else begin
                            r_c <= (r_nl[r_m[KBits-1:0]] <= r_nc) ? r_nl[r_m[KBits-1:0]] - 4'd1
                                                                  : 4'd0;
                            r_votes[(r_nl[r_m[KBits-1:0]] <= r_nc) ?
                                    r_nl[r_m[KBits-1:0]] - 4'd1 : 4'd0] <=
                                r_votes[(r_nl[r_m[KBits-1:0]] <= r_nc) ?
                                        r_nl[r_m[KBits-1:0]] - 4'd1 : 4'd0] + 5'd1;
                            r_sums[(r_nl[r_m[KBits-1:0]] <= r_nc) ?
                                   r_nl[r_m[KBits-1:0]] - 4'd1 : 4'd0] <=
                                r_sums[(r_nl[r_m[KBits-1:0]] <= r_nc) ?
                                       r_nl[r_m[KBits-1:0]] - 4'd1 : 4'd0]
                                + SumBits'(r_nd[r_m[KBits-1:0]]);
                        end
                        r_m <= r_m + 5'd1;
                    end else begin
                        r_best  <= '0;
                        r_c     <= 4'd1;
                        r_state <= S_BEST;
                    end
                end
                S_BEST: begin
                    if (r_c < r_nc) begin
                        if (r_votes[r_c] > r_votes[r_best]) r_best <= r_c;
                        r_c <= r_c + 4'd1;
                    end else begin
                        r_prod  <= SumBits'((r_thr_v[r_best] ? r_thr[r_best] : '0)
                                   * r_votes[r_best]);
                        r_state <= S_REJ;
                    end
                end
                S_REJ: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_oq_v || i_ready) begin
                        r_oq_v <= 1'b1;
                        if (r_zero) begin
                            r_oq <= '{predicted_label: 4'd0, vote_count: 5'd0,
                                      error_code: ERR_ZERO_LAB};
                        end else begin
                            r_oq.vote_count <= r_votes[r_best];
                            r_oq.error_code <= ERR_OK;
                            r_oq.predicted_label <= (i_null_reject_enable &&
                                r_sums[r_best] > r_prod) ? 4'd0 : r_best + 4'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/knn_classifier_null_reject_top.sv]
// Clear, threshold and non-last feature items are taken without leaving a result; a training last
// item's result is valid the cycle after it is taken. A query last item steps, per stored
// sample, through the distance sum, the integer square root for the Euclidean method and
// the farthest-neighbour search, then through the vote count, best-class search and reject test.
// No item is taken while a result waits or a scan runs. Reset is synchronous, active low;
// it empties the store, clears the thresholds and returns the configuration to defaults.
module knn_classifier_null_reject_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    knn_in_if.sink      in_ch,
    knn_out_if.source   out_ch,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data
);
    import knn_pkg::*;

    logic [4:0] r_k, r_len;
    logic       r_meth, r_rej;
    logic [3:0] r_nc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= 5'd1; r_meth <= 1'b0; r_rej <= 1'b0; r_len <= 5'd1; r_nc <= 4'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgK:      r_k    <= i_cfg_data;
                CfgMethod: r_meth <= i_cfg_data[0];
                CfgReject: r_rej  <= i_cfg_data[0];
                CfgLength: r_len  <= i_cfg_data;
                CfgClass:  r_nc   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    logic job_v, job_r, busy, st_we, lab_we, q_we, th_we;
    t_job job;
    logic [StoreBits-1:0] st_addr;
    logic [FeatureBits-1:0] st_data;
    logic [SampleBits-1:0] lab_addr;
    logic [3:0] lab_data, th_idx;
    logic [DimBits-1:0] q_addr;

    knn_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(in_ch.valid), .o_ready(in_ch.ready), .i_item(in_ch.data),
        .i_vector_length(r_len), .i_neighbour_count(r_k),
        .o_job_valid(job_v), .i_job_ready(job_r), .o_job(job), .i_busy(busy),
        .o_st_we(st_we), .o_st_addr(st_addr), .o_st_data(st_data),
        .o_lab_we(lab_we), .o_lab_addr(lab_addr), .o_lab_data(lab_data),
        .o_q_we(q_we), .o_q_addr(q_addr), .o_th_we(th_we), .o_th_idx(th_idx)
    );

    knn_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(job_v), .o_job_ready(job_r), .i_job(job), .o_busy(busy),
        .i_neighbour_count(r_k), .i_distance_method(r_meth),
        .i_null_reject_enable(r_rej), .i_vector_length(r_len), .i_num_classes(r_nc),
        .i_st_we(st_we), .i_st_addr(st_addr), .i_st_data(st_data),
        .i_lab_we(lab_we), .i_lab_addr(lab_addr), .i_lab_data(lab_data),
        .i_q_we(q_we), .i_q_addr(q_addr),
        .i_th_data(in_ch.data.threshold_value), .i_th_we(th_we), .i_th_idx(th_idx),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready), .o_data(out_ch.data)
    );

`ifndef NO_ASSERTIONS
    // A finished result is held until the sink takes it.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result dropped under stall");
    // Errors never name a class.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.data.error_code != ERR_OK |-> out_ch.data.predicted_label == 4'd0)
        else $error("label on error");
    // No query feature is taken while a scan reads the query buffer.
    a_qbuf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !q_we)
        else $error("query buffer written during scan");
`endif
endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import knn_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [4:0] i_cfg_data = '0;

    knn_in_if  in_ch ();
    knn_out_if out_ch ();

    knn_classifier_null_reject_top dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the classifier state.
    logic signed [15:0] feat_mem [MaxSamples][MaxDims];
    logic [3:0]         lab_mem [MaxSamples];
    int unsigned        n_samples;
    logic [23:0]        thr_mem [MaxClasses];
    logic signed [15:0] qry_mem [MaxDims];
    int unsigned        elem_cnt;
    bit                 ovf;
    int unsigned        k_reg, meth_reg, rej_reg, len_reg, ncls_reg;

    t_out        expected_q [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          out_wait = 0;
    bit          timed_out = 1'b0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned sample_dist(int unsigned s);
        longint unsigned acc, a;
        longint d;
        acc = 0;
        for (int j = 0; j < len_reg && j < MaxDims; j++) begin
            d = longint'(qry_mem[j]) - longint'(feat_mem[s][j]);
            a = (d < 0) ? -d : d;
            acc += meth_reg ? a : a * a;
        end
        return meth_reg ? acc : int_sqrt(acc);
    endfunction

    function automatic t_out classify_query();
        longint unsigned nd [MaxK];
        int unsigned     nl [MaxK];
        longint unsigned sums [MaxClasses];
        int unsigned     votes [MaxClasses];
        int unsigned     k, nc, n, best, mi, c;
        longint unsigned d;
        t_out            r;
        r = '0;
        k = (k_reg == 0) ? 1 : (k_reg > MaxK ? MaxK : k_reg);
        nc = (ncls_reg == 0) ? 1 : ncls_reg;
        n = 0;
        best = 0;
        if (k > n_samples) begin
            r.error_code = ERR_K_LARGE;
            return r;
        end
        for (int i = 0; i < n_samples; i++) begin
            d = sample_dist(i);
            if (n < k) begin
                nd[n] = d;
                nl[n] = lab_mem[i];
                n++;
            end else begin
                mi = 0;
                for (int m = 1; m < n; m++) if (nd[m] > nd[mi]) mi = m;
                if (d < nd[mi]) begin
                    nd[mi] = d;
                    nl[mi] = lab_mem[i];
                end
            end
        end
        for (int i = 0; i < MaxClasses; i++) begin
            sums[i] = 0;
            votes[i] = 0;
        end
        for (int i = 0; i < n; i++) begin
            if (nl[i] == 0) begin
                r.error_code = ERR_ZERO_LAB;
                return r;
            end
            c = (nl[i] <= nc) ? nl[i] - 1 : 0;
            votes[c]++;
            sums[c] += nd[i];
        end
        for (int i = 1; i < nc; i++) if (votes[i] > votes[best]) best = i;
        r.vote_count = 5'(votes[best]);
        if (rej_reg && sums[best] > longint'(thr_mem[best]) * votes[best])
            r.predicted_label = 4'd0;
        else
            r.predicted_label = 4'(best + 1);
        return r;
    endfunction

    function automatic void predict_item(t_in it);
        bit   good;
        t_out r;
        r = '0;
        case (t_func'(it.func))
            FUNC_CLEAR: begin
                n_samples = 0;
                elem_cnt = 0;
                ovf = 1'b0;
                return;
            end
            FUNC_THRESH: begin
                if (it.class_label >= 1 && it.class_label <= MaxClasses)
                    thr_mem[it.class_label-1] = it.threshold_value;
                return;
            end
            default: ;
        endcase
        if (elem_cnt < MaxDims && elem_cnt < len_reg &&
            (it.func == FUNC_QUERY || n_samples < MaxSamples)) begin
            if (it.func == FUNC_TRAIN) feat_mem[n_samples][elem_cnt] = it.feature_value;
            else qry_mem[elem_cnt] = it.feature_value;
            elem_cnt++;
        end else begin
            ovf = 1'b1;
        end
        if (!it.last_feature) return;
        good = !ovf && elem_cnt == len_reg;
        elem_cnt = 0;
        ovf = 1'b0;
        if (it.func == FUNC_TRAIN) begin
            if (good && n_samples < MaxSamples) begin
                lab_mem[n_samples] = it.class_label;
                n_samples++;
            end else begin
                r.error_code = ERR_LENGTH;
            end
        end else if (n_samples == 0) begin
            r.error_code = ERR_EMPTY;
        end else if (!good) begin
            r.error_code = ERR_LENGTH;
        end else begin
            r = classify_query();
        end
        expected_q = {expected_q, r};
    endfunction

    task automatic send_item(t_func f, logic signed [15:0] fv, logic [3:0] lab,
                             bit last, logic [23:0] thr);
        t_in it;
        int  gap;
        it.func = f;
        it.feature_value = fv;
        it.class_label = lab;
        it.last_feature = last;
        it.threshold_value = thr;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_item(it);
    endtask

    task automatic go_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        // Threshold and clear items leave no result; let them finish.
        repeat (8) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic write_reg(logic [2:0] idx, int unsigned val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= 5'(val);
        @(posedge i_clk);
        case (idx)
            CfgK:      k_reg = val & 5'h1f;
            CfgMethod: meth_reg = val & 1;
            CfgReject: rej_reg = val & 1;
            CfgLength: len_reg = val & 5'h1f;
            CfgClass:  ncls_reg = val & 4'hf;
            default: ;
        endcase
    endtask

    task automatic configure(int unsigned k, int unsigned m, int unsigned rj,
                             int unsigned len, int unsigned nc);
        go_idle();
        write_reg(CfgK, k);
        write_reg(CfgMethod, m);
        write_reg(CfgReject, rj);
        write_reg(CfgLength, len);
        write_reg(CfgClass, nc);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_feature();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom_range(0, 15) - 8);
            default: return 16'($urandom());
        endcase
    endfunction

    // Sends a vector of len features; last is flagged on the final one.
    task automatic send_vector(t_func f, int unsigned len, logic [3:0] lab);
        for (int j = 0; j < len; j++)
            send_item(f, rand_feature(), lab, j == len - 1, 24'($urandom()));
    endtask

    task automatic test_directed();
        send_vector(FUNC_QUERY, 1, 0);                 // empty store
        send_vector(FUNC_TRAIN, 1, 1);
        send_item(FUNC_TRAIN, 16'sh7fff, 2, 1'b0, '0); // too long
        send_item(FUNC_TRAIN, 16'sh8000, 2, 1'b1, '0);
        send_item(FUNC_TRAIN, 16'sh8000, 0, 1'b1, '0); // zero label stored
        send_item(FUNC_THRESH, 0, 1, 1'b0, 24'hffffff);
        send_item(FUNC_THRESH, 0, 0, 1'b0, 24'h000001);
        send_item(FUNC_THRESH, 0, 15, 1'b0, 24'h000000);
        send_item(FUNC_QUERY, 16'sh7fff, 0, 1'b1, '0);
        configure(3, 1, 1, 2, 2);
        send_vector(FUNC_QUERY, 2, 0);                 // K exceeds samples
        send_item(FUNC_QUERY, 16'sh7fff, 0, 1'b1, '0); // short
        send_item(FUNC_CLEAR, 0, 0, 1'b0, '0);
        send_vector(FUNC_TRAIN, 2, 15);                // label above classes
        send_vector(FUNC_TRAIN, 2, 2);
        send_vector(FUNC_TRAIN, 2, 1);
        send_vector(FUNC_QUERY, 2, 0);
        configure(0, 0, 1, 16, 15);
        send_vector(FUNC_QUERY, 16, 0);                // length mismatch
        send_item(FUNC_CLEAR, 0, 0, 1'b0, '0);
    endtask

    task automatic test_random_sessions();
        int unsigned len, nc, ns;
        for (int s = 0; s < 24; s++) begin
            len = (s % 6 == 0) ? 16 : $urandom_range(1, 4);
            nc = (s == 1) ? 15 : $urandom_range(0, 15);
            configure((s == 2) ? 31 : $urandom_range(0, 16), $urandom_range(0, 1),
                      $urandom_range(0, 1), len, nc);
            send_item(FUNC_CLEAR, 0, 0, 1'b0, '0);
            for (int c = 0; c < 4; c++)
                send_item(FUNC_THRESH, 0, 4'($urandom_range(0, 15)), 1'b0,
                          24'($urandom_range(0, 3) == 0 ? $urandom()
                                                        : $urandom_range(0, 40000)));
            ns = $urandom_range(3, 12);
            for (int i = 0; i < ns; i++) begin
                if ($urandom_range(0, 15) == 0)
                    send_vector(FUNC_TRAIN, len + 1, 4'($urandom_range(1, 15)));
                else
                    send_vector(FUNC_TRAIN, len,
                                4'($urandom_range(0, 30) == 0 ? 0 : $urandom_range(1, 15)));
            end
            for (int q = 0; q < 3; q++) begin
                if ($urandom_range(0, 7) == 0 && len > 1)
                    send_vector(FUNC_QUERY, len - 1, 0);
                else
                    send_vector(FUNC_QUERY, len, 0);
            end
        end
    endtask

    task automatic test_store_overflow();
        configure(16, 1, 0, 1, 15);
        send_item(FUNC_CLEAR, 0, 0, 1'b0, '0);
        for (int i = 0; i < MaxSamples + 2; i++)
            send_vector(FUNC_TRAIN, 1, 4'($urandom_range(1, 15)));
        send_vector(FUNC_QUERY, 1, 0);
        send_vector(FUNC_QUERY, 1, 0);
    endtask

    // The sink holds ready low until out_wait counts down; out_wait is drawn anew after each result it takes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_wait = $urandom_range(0, 3);
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", out_ch.data);
                end else begin
                    if (out_ch.data !== expected_q[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p",
                                     expected_q[0], out_ch.data);
                    end
                    void'(expected_q.pop_front());
                end
                out_wait = $urandom_range(0, 3);
            end else if (out_wait != 0) begin
                out_wait--;
            end
            out_ch.ready <= (out_wait == 0);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (i_rst_n && idle_cycles > 200000 && !timed_out) begin
            timed_out = 1'b1;
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        n_samples = 0;
        elem_cnt = 0;
        ovf = 1'b0;
        k_reg = 1; meth_reg = 0; rej_reg = 0; len_reg = 1; ncls_reg = 1;
        for (int i = 0; i < MaxClasses; i++) thr_mem[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_sessions();
        test_store_overflow();
        go_idle();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
